@@ design/acl_pkg.sv @@
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, constants and the inverse table for the affine letter cipher.
// ----------------------------------------------------------------------------
package acl_pkg;

	// alphabet size and base letter
	localparam logic [4:0] ALPHA_LEN = 5'd26;
	localparam logic [7:0] LETTER_A  = 8'd97;

	// widths
	localparam int CHAR_W  = 8;
	localparam int KEY_W   = 5;
	localparam int IDX_W   = 2;
	localparam int PROD_W  = 10;
	localparam int QPROD_W = 20;

	// floor(x / 26) as (x * 631) >> 14, exact for x up to 744
	localparam logic [9:0] RECIP_26    = 10'd631;
	localparam int         RECIP_SHIFT = 14;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_KEY_A  = 2'd0;
	localparam logic [IDX_W-1:0] REG_KEY_B  = 2'd1;
	localparam logic [IDX_W-1:0] REG_DECRYPT = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NOT_LETTER = 2'd1;
	localparam logic [1:0] STAT_NO_INVERSE = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic mul;
		logic quot;
		logic red;
		logic take;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic bypass;
		logic slot_free;
	} sts_t;

	// inverse modulo 26: msb is the valid flag, low bits the inverse
	function automatic logic [KEY_W:0] inv_lookup(input logic [KEY_W-1:0] a);
		logic [KEY_W:0] r;
		case (a)
			5'd1:    r = {1'b1, 5'd1};
			5'd3:    r = {1'b1, 5'd9};
			5'd5:    r = {1'b1, 5'd21};
			5'd7:    r = {1'b1, 5'd15};
			5'd9:    r = {1'b1, 5'd3};
			5'd11:   r = {1'b1, 5'd19};
			5'd15:   r = {1'b1, 5'd7};
			5'd17:   r = {1'b1, 5'd23};
			5'd19:   r = {1'b1, 5'd11};
			5'd21:   r = {1'b1, 5'd5};
			5'd23:   r = {1'b1, 5'd17};
			5'd25:   r = {1'b1, 5'd25};
			default: r = {1'b0, 5'd0};
		endcase
		return r;
	endfunction

endpackage

@@ design/acl_if.sv @@
// ----------------------------------------------------------------------------
// acl_if
// Valid/ready channels for input letters and cipher results.
// ----------------------------------------------------------------------------
interface acl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface acl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [1:0] status;

	modport source (output valid, output out_char, output status, input ready);
	modport sink   (input valid, input out_char, input status, output ready);
endinterface

@@ design/acl_ctrl.sv @@
// ----------------------------------------------------------------------------
// acl_ctrl
// Sequencer: prepare operands, multiply, reduce modulo 26 (skipped for a bypassed byte), hand off result.
// ----------------------------------------------------------------------------
module acl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acl_pkg::sts_t sts,
	output acl_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_QUOT  = 6'b001000,
		ST_RED   = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sts.bypass ? ST_WRITE : ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_RED;
			end
			ST_RED: begin
				cmd.red = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.take = sts.slot_free;
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PREP))
		else $error("accepted transaction did not start preparation");

	a_red_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) |=> (state_q == ST_WRITE))
		else $error("reduction did not end after its single step");

	a_take_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == ST_IDLE && in_ready))
		else $error("controller not idle after result hand-off");
`endif

endmodule

@@ design/acl_dp.sv @@
// ----------------------------------------------------------------------------
// acl_dp
// Key registers, operand selection, multiplier, remainder unit, result slot.
// ----------------------------------------------------------------------------
module acl_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [acl_pkg::IDX_W-1:0]    cfg_index,
	input  logic [acl_pkg::KEY_W-1:0]    cfg_data,
	input  logic [acl_pkg::CHAR_W-1:0]   in_char,
	input  acl_pkg::cmd_t                cmd,
	output acl_pkg::sts_t                sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [acl_pkg::CHAR_W-1:0]   out_char,
	output logic [1:0]                   status
);

	logic [acl_pkg::KEY_W-1:0]  key_a_q, key_b_q;
	logic                       decrypt_q;
	logic [acl_pkg::CHAR_W-1:0] char_q;
	logic [acl_pkg::KEY_W-1:0]  m_q, n_q, add_q;
	logic [1:0]                 stat_q;
	logic [acl_pkg::PROD_W-1:0] rem_q;
	logic [acl_pkg::KEY_W-1:0]  q_q;
	logic                       out_valid_q;
	logic [acl_pkg::CHAR_W-1:0] out_char_q;
	logic [1:0]                 status_q;

	logic [acl_pkg::KEY_W-1:0]   a_red, b_red, p, d, inv;
	logic                        inv_ok, is_letter;
	logic [acl_pkg::KEY_W:0]     inv_entry, p_plus;
	logic [acl_pkg::QPROD_W-1:0] qprod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q   <= 5'd1;
			key_b_q   <= 5'd0;
			decrypt_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				acl_pkg::REG_KEY_A:   key_a_q   <= cfg_data;
				acl_pkg::REG_KEY_B:   key_b_q   <= cfg_data;
				acl_pkg::REG_DECRYPT: decrypt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key reduction, letter check and inverse lookup
	always_comb begin
		a_red     = (key_a_q >= acl_pkg::ALPHA_LEN) ? key_a_q - acl_pkg::ALPHA_LEN : key_a_q;
		b_red     = (key_b_q >= acl_pkg::ALPHA_LEN) ? key_b_q - acl_pkg::ALPHA_LEN : key_b_q;
		is_letter = (char_q >= acl_pkg::LETTER_A) &&
		            (char_q < acl_pkg::LETTER_A + 8'(acl_pkg::ALPHA_LEN));
		p         = acl_pkg::KEY_W'(char_q - acl_pkg::LETTER_A);
		inv_entry = acl_pkg::inv_lookup(a_red);
		inv_ok    = inv_entry[acl_pkg::KEY_W];
		inv       = inv_entry[acl_pkg::KEY_W-1:0];
		// (p - b) mod 26 without going negative
		p_plus    = {1'b0, p} + {1'b0, acl_pkg::ALPHA_LEN} - {1'b0, b_red};
		d         = (p >= b_red) ? p - b_red : p_plus[acl_pkg::KEY_W-1:0];
		// quotient estimate by reciprocal multiplication
		qprod     = acl_pkg::QPROD_W'(rem_q) * acl_pkg::QPROD_W'(acl_pkg::RECIP_26);
	end

	// operand, product, quotient and remainder registers
	always_ff @(posedge clk) begin
		if (cmd.load) char_q <= in_char;
		if (cmd.prep) begin
			m_q   <= decrypt_q ? inv : a_red;
			n_q   <= decrypt_q ? d : p;
			add_q <= decrypt_q ? '0 : b_red;
			if (!is_letter) stat_q <= acl_pkg::STAT_NOT_LETTER;
			else if (decrypt_q && !inv_ok) stat_q <= acl_pkg::STAT_NO_INVERSE;
			else stat_q <= acl_pkg::STAT_OK;
		end
		if (cmd.quot) q_q <= qprod[acl_pkg::RECIP_SHIFT +: acl_pkg::KEY_W];
		if (cmd.mul) begin
			rem_q <= acl_pkg::PROD_W'(m_q) * acl_pkg::PROD_W'(n_q) + acl_pkg::PROD_W'(add_q);
		end else if (cmd.red) begin
			rem_q <= rem_q - acl_pkg::PROD_W'(q_q) * acl_pkg::PROD_W'(acl_pkg::ALPHA_LEN);
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			out_char_q <= (stat_q == acl_pkg::STAT_OK) ?
			              acl_pkg::LETTER_A + acl_pkg::CHAR_W'(rem_q[acl_pkg::KEY_W-1:0]) :
			              char_q;
			status_q   <= stat_q;
		end
	end

	assign sts.bypass    = (stat_q != acl_pkg::STAT_OK);
	assign sts.slot_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && stat_q == acl_pkg::STAT_OK) |-> (rem_q < 10'(acl_pkg::ALPHA_LEN)))
		else $error("remainder not reduced below 26 at hand-off");

	a_take_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (!out_valid_q || out_ready))
		else $error("result written over a pending transaction");
`endif

endmodule

@@ design/affine_cipher_letter_core.sv @@
// sequence: an accepted letter is prepared, multiplied, divided by 26 for a quotient
// and reduced before hand-off; a passed-through byte or a key with no inverse skips
// quotient and reduction; hand-off waits while the output slot is still full, and
// a new byte is accepted only after the previous result has been handed off
// reset: arst_n clears state and restores key_a 1, key_b 0, encrypt mode
// ----------------------------------------------------------------------------
// affine_cipher_letter_core
// Affine cipher on lower-case letter bytes, mod 26, encrypt or decrypt; other bytes pass through.
// ----------------------------------------------------------------------------
module affine_cipher_letter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [acl_pkg::IDX_W-1:0]  cfg_index,
	input  logic [acl_pkg::KEY_W-1:0]  cfg_data,
	acl_in_if.sink                     text_ch,
	acl_out_if.source                  result_ch
);

	acl_pkg::cmd_t cmd;
	acl_pkg::sts_t sts;

	// controller
	acl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_ch.valid),
		.in_ready (text_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	acl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (text_ch.in_char),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.out_char  (result_ch.out_char),
		.status    (result_ch.status)
	);

endmodule
